// File: sv/multi_channel_servo_ramp_macros.svh
// Assertion macros for the servo ramp block.
// Included by the top level; no other dependencies.
`ifndef MULTI_CHANNEL_SERVO_RAMP_MACROS_SVH
`define MULTI_CHANNEL_SERVO_RAMP_MACROS_SVH
`ifndef SYNTH
`define MCSR_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("servo ramp check failed");
`define MCSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("servo ramp check failed");
`else
`define MCSR_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define MCSR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/mcsr_pkg.sv
// Shared types and constants of the servo ramp block.
// No dependencies; imported by mcsr_alu, multi_channel_servo_ramp and the testbench.
package mcsr_pkg;

	localparam int RAMP_CHANNELS = 5;
	localparam int ALL_CHANNELS  = 8;
	localparam int SPEED_LEVELS  = 4;
	localparam int POS_BITS      = 10;
	localparam int TABLE_BITS    = 50;
	localparam int STEP_BITS     = 5;
	localparam int STEP_FIELD    = 4;
	localparam int DUTY_FIELD    = 8;
	localparam int CH_BITS       = 4;
	localparam int TIME_BITS     = 11;
	localparam int PULSE_BITS    = 12;
	localparam int DRIVE_BITS    = 9;
	localparam int IDX_BITS      = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int SUM_BITS      = POS_BITS + 2;

	localparam logic [POS_BITS-1:0]   POS_RESET  = POS_BITS'(500);
	localparam logic [PULSE_BITS-1:0] PULSE_BASE = PULSE_BITS'(500);
	localparam logic [DRIVE_BITS-1:0] ANGLE_FWD  = DRIVE_BITS'(180);
	localparam logic [DRIVE_BITS-1:0] ANGLE_STOP = DRIVE_BITS'(90);
	localparam logic [TIME_BITS-1:0]  TICK_MS    = TIME_BITS'(50);
	localparam logic [TIME_BITS-1:0]  RESET_MS   = TIME_BITS'(2000);

	localparam logic [TABLE_BITS-1:0] POS_MIN_RST = 50'd52429000;
	localparam logic [TABLE_BITS-1:0] POS_MAX_RST = 50'd1100586366700520;
	localparam logic [TABLE_BITS-1:0] POS_DEF_RST = 50'd550701703792840;
	localparam logic [7:0]            DIR_REV_RST = 8'd10;
	localparam logic [15:0]           STEP_TBL_RST = 16'd51283;
	localparam logic [31:0]           DUTY_TBL_RST = 32'd3028444210;

	typedef enum logic [1:0] {
		REQ_TICK  = 2'd0,
		REQ_SPEED = 2'd1,
		REQ_RESET = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_POS_MIN  = 3'd0,
		CFG_POS_MAX  = 3'd1,
		CFG_POS_DEF  = 3'd2,
		CFG_DIR_REV  = 3'd3,
		CFG_STEP_TBL = 3'd4,
		CFG_DUTY_TBL = 3'd5
	} cfg_idx_t;

	// Result of one pass through the shared position unit
	typedef struct packed {
		logic                  in_win;
		logic [POS_BITS-1:0]   pos;
		logic [PULSE_BITS-1:0] pulse;
	} alu_res_t;

endpackage

// File: sv/mcsr_alu.sv
// Shared position unit: step add, window compare and pulse width.
// Depends on mcsr_pkg.
module mcsr_alu (
	input  logic [mcsr_pkg::POS_BITS-1:0]  pos,
	input  logic [mcsr_pkg::STEP_BITS-1:0] step,
	input  logic [mcsr_pkg::POS_BITS-1:0]  lo,
	input  logic [mcsr_pkg::POS_BITS-1:0]  hi,
	output mcsr_pkg::alu_res_t             res
);
	import mcsr_pkg::*;

	logic signed [SUM_BITS-1:0] sum;
	logic signed [SUM_BITS-1:0] lo_x;
	logic signed [SUM_BITS-1:0] hi_x;

	assign sum  = $signed({2'b00, pos})
		+ $signed({{(SUM_BITS-STEP_BITS){step[STEP_BITS-1]}}, step});
	assign lo_x = $signed({2'b00, lo});
	assign hi_x = $signed({2'b00, hi});

	always_comb begin
		res.in_win = (sum >= lo_x) && (sum <= hi_x);
		// hold the old position when the step would leave the window
		res.pos    = res.in_win ? sum[POS_BITS-1:0] : pos;
		res.pulse  = PULSE_BITS'({res.pos, 1'b0}) + PULSE_BASE;
	end

endmodule

// File: sv/multi_channel_servo_ramp.sv
// Tick (only while a ramp is running): 5 output words, one per cycle while the output does not stall.
// Reset command: 8 words. Motor/angle command: 1 word.
// Ramp-channel speed command: no word, ready again next cycle; bad channels and unused types yield none.
// One adder/compare unit walks the ramp channels; output stalls hold the walk.
// arst_n clears control, config registers, positions (500) and steps asynchronously.
// Depends on mcsr_pkg, mcsr_alu and multi_channel_servo_ramp_macros.svh.
`include "multi_channel_servo_ramp_macros.svh"
module multi_channel_servo_ramp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            req_type,
	input  logic [mcsr_pkg::CH_BITS-1:0]          channel,
	input  logic signed [3:0]                     speed_level,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [mcsr_pkg::CH_BITS-1:0]          out_channel,
	output logic [mcsr_pkg::POS_BITS-1:0]         out_position,
	output logic [mcsr_pkg::TIME_BITS-1:0]        out_time_ms,
	output logic [mcsr_pkg::PULSE_BITS-1:0]       out_pulse_us,
	output logic signed [mcsr_pkg::DRIVE_BITS-1:0] out_drive,
	output logic                                  last,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [mcsr_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [mcsr_pkg::TABLE_BITS-1:0]       cfg_data
);
	import mcsr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TICK = 4'b0010,
		ST_RST  = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [IDX_BITS-1:0]    idx_q;
	logic                   any_q;
	logic                   ramping_q;
	logic [CH_BITS-1:0]     cmd_ch_q;
	logic [DRIVE_BITS-1:0]  cmd_drive_q;

	logic [TABLE_BITS-1:0]  pos_min_q, pos_max_q, pos_def_q;
	logic [7:0]             dir_rev_q;
	logic [15:0]            step_tbl_q;
	logic [31:0]            duty_tbl_q;

	logic [POS_BITS-1:0]    goal_q [RAMP_CHANNELS];
	logic [STEP_BITS-1:0]   step_q [RAMP_CHANNELS];

	logic                   out_valid_q;
	logic [CH_BITS-1:0]     out_ch_q;
	logic [POS_BITS-1:0]    out_pos_q;
	logic [TIME_BITS-1:0]   out_time_q;
	logic [PULSE_BITS-1:0]  out_pulse_q;
	logic [DRIVE_BITS-1:0]  out_drive_q;
	logic                   out_last_q;

	// ---------------- speed command decode ----------------
	logic                   in_accept;
	logic                   ch_ok, ch_ramp, ch_angle;
	logic [IDX_BITS-1:0]    ch_idx;
	logic signed [4:0]      spd_x, spd_r;
	logic                   spd_neg, spd_nz;
	logic [3:0]             mag;
	logic [2:0]             mag_sat;
	logic [1:0]             lvl;
	logic [STEP_FIELD-1:0]  st_field;
	logic [DUTY_FIELD-1:0]  duty_field;
	logic [STEP_BITS-1:0]   step_new;
	logic [DRIVE_BITS-1:0]  drive_new;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		ch_ok    = (channel >= CH_BITS'(1)) && (channel <= CH_BITS'(ALL_CHANNELS));
		ch_ramp  = (channel <= CH_BITS'(RAMP_CHANNELS));
		ch_angle = (channel == CH_BITS'(RAMP_CHANNELS + 1));
		ch_idx   = IDX_BITS'(channel - CH_BITS'(1));
		spd_x    = {speed_level[3], speed_level};
		spd_r    = dir_rev_q[ch_idx] ? -spd_x : spd_x;
		spd_neg  = spd_r[4];
		spd_nz   = (spd_r != 5'sd0);
		mag      = spd_neg ? 4'(-spd_r) : 4'(spd_r);
		mag_sat  = (mag > 4'(SPEED_LEVELS)) ? 3'(SPEED_LEVELS) : 3'(mag);
		lvl      = 2'(mag_sat - 3'd1);
		st_field   = spd_nz ? step_tbl_q[lvl*STEP_FIELD +: STEP_FIELD] : '0;
		duty_field = spd_nz ? duty_tbl_q[lvl*DUTY_FIELD +: DUTY_FIELD] : '0;
		step_new = spd_neg ? -{1'b0, st_field} : {1'b0, st_field};
		if (ch_angle) begin
			if (!spd_nz)
				drive_new = ANGLE_STOP;
			else if (spd_neg)
				drive_new = '0;
			else
				drive_new = ANGLE_FWD;
		end else begin
			drive_new = spd_neg ? -{1'b0, duty_field} : {1'b0, duty_field};
		end
	end

	// ---------------- shared position unit ----------------
	logic [IDX_BITS-1:0]    ridx;
	logic                   is_tick;
	logic [POS_BITS-1:0]    alu_pos, alu_lo, alu_hi;
	logic [STEP_BITS-1:0]   alu_step;
	alu_res_t               alu_res;

	always_comb begin
		ridx     = (idx_q < IDX_BITS'(RAMP_CHANNELS)) ? idx_q : '0;
		is_tick  = (state_q == ST_TICK);
		alu_pos  = is_tick ? goal_q[ridx] : pos_def_q[ridx*POS_BITS +: POS_BITS];
		alu_step = is_tick ? step_q[ridx] : '0;
		alu_lo   = is_tick ? pos_min_q[ridx*POS_BITS +: POS_BITS] : '0;
		alu_hi   = is_tick ? pos_max_q[ridx*POS_BITS +: POS_BITS] : '1;
	end

	mcsr_alu u_alu (
		.pos  (alu_pos),
		.step (alu_step),
		.lo   (alu_lo),
		.hi   (alu_hi),
		.res  (alu_res)
	);

	// ---------------- sequencer ----------------
	logic                   slot_free, adv;
	logic                   idx_ramp, idx_end_ramp, idx_end_all;
	logic                   step_live;
	logic [CH_BITS-1:0]     ld_ch;
	logic [POS_BITS-1:0]    ld_pos;
	logic [TIME_BITS-1:0]   ld_time;
	logic [PULSE_BITS-1:0]  ld_pulse;
	logic [DRIVE_BITS-1:0]  ld_drive;
	logic                   ld_last;

	assign slot_free = !out_valid_q || !out_stall;
	assign adv       = slot_free && (state_q != ST_IDLE);

	always_comb begin
		idx_ramp     = (idx_q < IDX_BITS'(RAMP_CHANNELS));
		idx_end_ramp = (idx_q == IDX_BITS'(RAMP_CHANNELS - 1));
		idx_end_all  = (idx_q == IDX_BITS'(ALL_CHANNELS - 1));
		step_live    = alu_res.in_win && (step_q[ridx] != '0);
		ld_ch    = CH_BITS'(idx_q) + CH_BITS'(1);
		ld_pos   = '0;
		ld_time  = '0;
		ld_pulse = '0;
		ld_drive = '0;
		ld_last  = 1'b0;
		unique case (state_q)
			ST_TICK: begin
				ld_pos   = alu_res.pos;
				ld_time  = TICK_MS;
				ld_pulse = idx_end_ramp ? alu_res.pulse : '0;
				ld_last  = idx_end_ramp;
			end
			ST_RST: begin
				if (idx_ramp) begin
					ld_pos   = alu_res.pos;
					ld_time  = RESET_MS;
					ld_pulse = idx_end_ramp ? alu_res.pulse : '0;
				end else if (idx_q == IDX_BITS'(RAMP_CHANNELS)) begin
					ld_drive = ANGLE_STOP;
				end
				ld_last = idx_end_all;
			end
			ST_EMIT: begin
				ld_ch    = cmd_ch_q;
				ld_drive = cmd_drive_q;
				ld_last  = 1'b1;
			end
			default: begin
				ld_ch = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			any_q       <= 1'b0;
			ramping_q   <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < RAMP_CHANNELS; i++) begin
				goal_q[i] <= POS_RESET;
				step_q[i] <= '0;
			end
		end else begin
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					any_q <= 1'b0;
					if (in_accept) begin
						unique case (req_type)
							REQ_TICK: begin
								if (ramping_q)
									state_q <= ST_TICK;
							end
							REQ_SPEED: begin
								if (ch_ok && ch_ramp) begin
									step_q[ch_idx] <= step_new;
									if (spd_nz)
										ramping_q <= 1'b1;
								end else if (ch_ok) begin
									state_q <= ST_EMIT;
								end
							end
							REQ_RESET: state_q <= ST_RST;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_TICK: begin
					if (adv) begin
						if (alu_res.in_win)
							goal_q[ridx] <= alu_res.pos;
						else
							step_q[ridx] <= '0;
						any_q <= any_q || step_live;
						idx_q <= idx_q + IDX_BITS'(1);
						if (idx_end_ramp) begin
							ramping_q <= any_q || step_live;
							state_q   <= ST_IDLE;
						end
					end
				end
				ST_RST: begin
					if (adv) begin
						if (idx_ramp)
							goal_q[ridx] <= alu_res.pos;
						idx_q <= idx_q + IDX_BITS'(1);
						if (idx_end_all)
							state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (adv)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// latch the single-word command result and load the output word registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_ch_q    <= channel;
			cmd_drive_q <= drive_new;
		end
		if (adv) begin
			out_ch_q    <= ld_ch;
			out_pos_q   <= ld_pos;
			out_time_q  <= ld_time;
			out_pulse_q <= ld_pulse;
			out_drive_q <= ld_drive;
			out_last_q  <= ld_last;
		end
	end

	// ---------------- configuration ----------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_min_q  <= POS_MIN_RST;
			pos_max_q  <= POS_MAX_RST;
			pos_def_q  <= POS_DEF_RST;
			dir_rev_q  <= DIR_REV_RST;
			step_tbl_q <= STEP_TBL_RST;
			duty_tbl_q <= DUTY_TBL_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_POS_MIN:  pos_min_q  <= cfg_data;
				CFG_POS_MAX:  pos_max_q  <= cfg_data;
				CFG_POS_DEF:  pos_def_q  <= cfg_data;
				CFG_DIR_REV:  dir_rev_q  <= cfg_data[7:0];
				CFG_STEP_TBL: step_tbl_q <= cfg_data[15:0];
				CFG_DUTY_TBL: duty_tbl_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign out_channel  = out_ch_q;
	assign out_position = out_pos_q;
	assign out_time_ms  = out_time_q;
	assign out_pulse_us = out_pulse_q;
	assign out_drive    = $signed(out_drive_q);
	assign last         = out_last_q;

	// ---------------- checks ----------------
	`MCSR_ASSERT_IMPL(a_ramp_stop_in_tick, clk, arst_n, $fell(ramping_q), $past(state_q == ST_TICK))
	`MCSR_ASSERT_NEXT(a_last_ends_seq, clk, arst_n, adv && ld_last, state_q == ST_IDLE)
	`MCSR_ASSERT_IMPL(a_tick_idx_range, clk, arst_n, state_q == ST_TICK, idx_q < IDX_BITS'(RAMP_CHANNELS))
	`MCSR_ASSERT_IMPL(a_tick_needs_ramp, clk, arst_n, state_q == ST_TICK, ramping_q)

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench of multi_channel_servo_ramp: a directed command table, then random
// phases under several register settings, every output word checked in order.
// Depends on mcsr_pkg and the RTL of the block.
module tb;
	import mcsr_pkg::*;

	localparam int REQ_UNUSED    = 3;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES   = 120;

	typedef struct {
		logic [CH_BITS-1:0]           ch;
		logic [POS_BITS-1:0]          pos;
		logic [TIME_BITS-1:0]         ms;
		logic [PULSE_BITS-1:0]        pulse;
		logic signed [DRIVE_BITS-1:0] drive;
		logic                         fin;
	} servo_word_t;

	typedef struct {
		int req;
		int ch;
		int lvl;
		bit typed;
		int n_words;
		int drive;
	} cmd_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [CH_BITS-1:0] channel = '0;
	logic signed [3:0] speed_level = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [CH_BITS-1:0] out_channel;
	logic [POS_BITS-1:0] out_position;
	logic [TIME_BITS-1:0] out_time_ms;
	logic [PULSE_BITS-1:0] out_pulse_us;
	logic signed [DRIVE_BITS-1:0] out_drive;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [TABLE_BITS-1:0] cfg_data = '0;

	// Shadow of the block: positions, steps and registers
	logic [POS_BITS-1:0] goal_pos [RAMP_CHANNELS];
	logic signed [STEP_BITS-1:0] ramp_step [RAMP_CHANNELS];
	bit ramp_on;
	logic [TABLE_BITS-1:0] lim_lo, lim_hi, home_tbl;
	logic [7:0] rev_mask;
	logic [15:0] step_tbl;
	logic [31:0] duty_tbl;

	servo_word_t servo_words_due[$];
	int mismatch_count = 0;
	int gap_pct = 29;
	int stall_pct = 29;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;

	cmd_row_t plan [25] = '{
		'{REQ_TICK,   0,  0, 1, 0, 0},
		'{REQ_UNUSED, 5,  7, 1, 0, 0},
		'{REQ_SPEED,  0,  3, 1, 0, 0},
		'{REQ_SPEED,  9,  1, 1, 0, 0},
		'{REQ_SPEED,  15, -8, 1, 0, 0},
		'{REQ_RESET,  0,  0, 1, 8, 0},
		'{REQ_SPEED,  6,  1, 1, 1, 180},
		'{REQ_SPEED,  6,  0, 1, 1, 90},
		'{REQ_SPEED,  6,  -8, 1, 1, 0},
		'{REQ_SPEED,  7,  7, 1, 1, 180},
		'{REQ_SPEED,  7,  -8, 1, 1, -180},
		'{REQ_SPEED,  8,  -1, 1, 1, -50},
		'{REQ_SPEED,  8,  3, 1, 1, 130},
		'{REQ_SPEED,  7,  0, 1, 1, 0},
		'{REQ_SPEED,  1,  7, 1, 0, 0},
		'{REQ_SPEED,  2,  -3, 1, 0, 0},
		'{REQ_SPEED,  3,  -8, 1, 0, 0},
		'{REQ_SPEED,  4,  2, 1, 0, 0},
		'{REQ_SPEED,  5,  -1, 1, 0, 0},
		'{REQ_TICK,   15, 7, 0, 0, 0},
		'{REQ_TICK,   0,  0, 0, 0, 0},
		'{REQ_SPEED,  1,  0, 1, 0, 0},
		'{REQ_TICK,   0,  -1, 0, 0, 0},
		'{REQ_RESET,  10, 5, 0, 0, 0},
		'{REQ_TICK,   0,  0, 0, 0, 0}
	};

	multi_channel_servo_ramp u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.req_type(req_type),
		.channel(channel),
		.speed_level(speed_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_channel(out_channel),
		.out_position(out_position),
		.out_time_ms(out_time_ms),
		.out_pulse_us(out_pulse_us),
		.out_drive(out_drive),
		.last(last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic void queue_word(int ch, int pos, int ms, int pulse, int drive, bit fin);
		servo_word_t w;
		w.ch = ch[CH_BITS-1:0];
		w.pos = pos[POS_BITS-1:0];
		w.ms = ms[TIME_BITS-1:0];
		w.pulse = pulse[PULSE_BITS-1:0];
		w.drive = drive[DRIVE_BITS-1:0];
		w.fin = fin;
		servo_words_due.push_back(w);
	endfunction

	function automatic void queue_ramp(int i, int ms, bit fin);
		int pulse;
		pulse = (i == RAMP_CHANNELS - 1) ? 2 * goal_pos[i] + PULSE_BASE : 0;
		queue_word(i + 1, goal_pos[i], ms, pulse, 0, fin);
	endfunction

	// Advance the shadow by one command word; return the number of words it yields
	function automatic int servo_ramp_step(int r, int ch, int lvl);
		int lo, hi, total, s, mag, st, d, n;
		bit moving;
		n = 0;
		if (r == REQ_TICK) begin
			if (ramp_on) begin
				moving = 1'b0;
				for (int i = 0; i < RAMP_CHANNELS; i++) begin
					lo = lim_lo[i*POS_BITS +: POS_BITS];
					hi = lim_hi[i*POS_BITS +: POS_BITS];
					total = goal_pos[i];
					total += ramp_step[i];
					// hold the old position and drop the step outside the window
					if (total < lo || total > hi) begin
						ramp_step[i] = '0;
					end else begin
						goal_pos[i] = total[POS_BITS-1:0];
					end
					if (ramp_step[i] != 0) moving = 1'b1;
					queue_ramp(i, TICK_MS, i == RAMP_CHANNELS - 1);
				end
				ramp_on = moving;
				n = RAMP_CHANNELS;
			end
		end else if (r == REQ_SPEED && ch >= 1 && ch <= ALL_CHANNELS) begin
			s = lvl;
			if (rev_mask[ch-1]) s = -s;
			mag = (s < 0) ? -s : s;
			if (mag > SPEED_LEVELS) mag = SPEED_LEVELS;
			if (ch <= RAMP_CHANNELS) begin
				st = (mag != 0) ? step_tbl[(mag-1)*STEP_FIELD +: STEP_FIELD] : 0;
				ramp_step[ch-1] = STEP_BITS'((s < 0) ? -st : st);
				if (s != 0) ramp_on = 1'b1;
			end else if (ch == RAMP_CHANNELS + 1) begin
				queue_word(ch, 0, 0, 0, (s > 0) ? ANGLE_FWD : ((s == 0) ? ANGLE_STOP : 0), 1'b1);
				n = 1;
			end else begin
				d = (mag != 0) ? duty_tbl[(mag-1)*DUTY_FIELD +: DUTY_FIELD] : 0;
				queue_word(ch, 0, 0, 0, (s < 0) ? -d : d, 1'b1);
				n = 1;
			end
		end else if (r == REQ_RESET) begin
			for (int i = 0; i < RAMP_CHANNELS; i++) begin
				goal_pos[i] = home_tbl[i*POS_BITS +: POS_BITS];
				queue_ramp(i, RESET_MS, 1'b0);
			end
			queue_word(RAMP_CHANNELS + 1, 0, 0, 0, ANGLE_STOP, 1'b0);
			for (int c = RAMP_CHANNELS + 2; c <= ALL_CHANNELS; c++) begin
				queue_word(c, 0, 0, 0, 0, c == ALL_CHANNELS);
			end
			n = ALL_CHANNELS;
		end
		return n;
	endfunction

	function automatic logic [TABLE_BITS-1:0] rand_table();
		return TABLE_BITS'({$urandom, $urandom});
	endfunction

	function automatic void check_field(string name, logic signed [PULSE_BITS:0] want,
			logic signed [PULSE_BITS:0] got);
		if (got !== want) begin
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	task automatic issue_cmd(input int r, input int ch, input int lvl, input bit typed,
			input int n_typed, input int drv_typed);
		int n;
		n = servo_ramp_step(r, ch, lvl);
		if (typed && (n != n_typed || (n == 1 &&
				servo_words_due[servo_words_due.size()-1].drive != drv_typed))) begin
			$display("%0t ns: command table row req %0d ch %0d expected %0d words drive %0d",
				$time, r, ch, n_typed, drv_typed);
			mismatch_count++;
		end
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= 2'(r);
		channel <= 4'(ch);
		speed_level <= 4'(lvl);
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drop valid, let every due word drain, then let the block go quiet
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (servo_words_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [TABLE_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_POS_MIN:  lim_lo = val;
			CFG_POS_MAX:  lim_hi = val;
			CFG_POS_DEF:  home_tbl = val;
			CFG_DIR_REV:  rev_mask = val[7:0];
			CFG_STEP_TBL: step_tbl = val[15:0];
			CFG_DUTY_TBL: duty_tbl = val[31:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [TABLE_BITS-1:0] lo, hi, home, mask, steps, duty);
		write_reg(CFG_POS_MIN, lo);
		write_reg(CFG_POS_MAX, hi);
		write_reg(CFG_POS_DEF, home);
		write_reg(CFG_DIR_REV, mask);
		write_reg(CFG_STEP_TBL, steps);
		write_reg(CFG_DUTY_TBL, duty);
		cfg_valid <= 1'b0;
	endtask

	// Random windows wide enough for long ramps, defaults inside them
	task automatic window_config();
		logic [TABLE_BITS-1:0] lo, hi, home;
		int l, h, d;
		for (int i = 0; i < RAMP_CHANNELS; i++) begin
			l = $urandom_range(400, 0);
			h = $urandom_range(1023, 600);
			d = $urandom_range(h, l);
			lo[i*POS_BITS +: POS_BITS] = l[POS_BITS-1:0];
			hi[i*POS_BITS +: POS_BITS] = h[POS_BITS-1:0];
			home[i*POS_BITS +: POS_BITS] = d[POS_BITS-1:0];
		end
		load_config(lo, hi, home, rand_table(), rand_table(), rand_table());
	endtask

	// Mostly ramp commands and ticks; some motor words, resets and junk
	task automatic run_phase(input int target);
		int done, r, ch, lvl, roll;
		done = 0;
		while (done < target) begin
			roll = $urandom_range(99);
			ch = $urandom_range(15);
			lvl = int'($urandom_range(15)) - 8;
			if (roll < 45) begin
				r = REQ_TICK;
			end else if (roll < 80) begin
				r = REQ_SPEED;
				ch = $urandom_range(RAMP_CHANNELS, 1);
			end else if (roll < 88) begin
				r = REQ_SPEED;
				ch = $urandom_range(ALL_CHANNELS, RAMP_CHANNELS + 1);
			end else if (roll < 93) begin
				r = REQ_RESET;
			end else if (roll < 97) begin
				r = REQ_SPEED;
				ch = $urandom_range(1) ? 0 : $urandom_range(15, ALL_CHANNELS + 1);
			end else begin
				r = REQ_UNUSED;
			end
			issue_cmd(r, ch, lvl, 1'b0, 0, 0);
			done++;
		end
	endtask

	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : word_check
		servo_word_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (servo_words_due.size() == 0) begin
				$display("%0t ns: word on channel %0d with none due", $time, out_channel);
				mismatch_count++;
			end else begin
				w = servo_words_due.pop_front();
				check_field("out_channel", w.ch, out_channel);
				check_field("out_position", w.pos, out_position);
				check_field("out_time_ms", w.ms, out_time_ms);
				check_field("out_pulse_us", w.pulse, out_pulse_us);
				check_field("out_drive", w.drive, out_drive);
				check_field("last", w.fin, last);
			end
		end
	end

	initial begin : stimulus
		lim_lo = POS_MIN_RST;
		lim_hi = POS_MAX_RST;
		home_tbl = POS_DEF_RST;
		rev_mask = DIR_REV_RST;
		step_tbl = STEP_TBL_RST;
		duty_tbl = DUTY_TBL_RST;
		for (int i = 0; i < RAMP_CHANNELS; i++) begin
			goal_pos[i] = POS_RESET;
			ramp_step[i] = '0;
		end
		ramp_on = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[k]) begin
			issue_cmd(plan[k].req, plan[k].ch, plan[k].lvl, plan[k].typed,
				plan[k].n_words, plan[k].drive);
		end
		wait_idle();

		// no gaps and no stalls for a while
		gap_pct = 0;
		stall_pct = 0;
		run_phase(50);
		gap_pct = 29;
		stall_pct = 29;
		wait_idle();

		load_config('1, '1, '1, '1, '1, '1);
		run_phase(40);
		wait_idle();

		load_config('0, '0, '0, '0, '0, '0);
		run_phase(35);
		wait_idle();

		// min above max on every channel: no tick may move anything
		load_config({RAMP_CHANNELS{10'd700}}, {RAMP_CHANNELS{10'd300}}, rand_table(),
			rand_table(), rand_table(), rand_table());
		run_phase(35);
		wait_idle();

		// hold the output long while words keep coming, then pause for a full drain
		window_config();
		run_phase(20);
		hold_requests++;
		gap_pct = 0;
		run_phase(30);
		gap_pct = 29;
		wait_idle();
		run_phase(25);
		wait_idle();

		window_config();
		run_phase(70);
		wait_idle();

		load_config(rand_table(), rand_table(), rand_table(), rand_table(), rand_table(),
			rand_table());
		run_phase(45);
		wait_idle();

		load_config(POS_MIN_RST, POS_MAX_RST, POS_DEF_RST, DIR_REV_RST, STEP_TBL_RST,
			DUTY_TBL_RST);
		run_phase(45);
		wait_idle();

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
